// ===== hw/rtl/mipse_pkg.sv =====
package mipse_pkg;

    typedef enum logic [3:0] {
        CLS_REPLY,
        CLS_JUMP,
        CLS_JAL,
        CLS_BRANCH,
        CLS_ALU,
        CLS_LOAD,
        CLS_STORE,
        CLS_FWD,
        CLS_UNKNOWN
    } cls_t;

    localparam logic [2:0] KIND_DONE    = 3'd0;
    localparam logic [2:0] KIND_LOAD    = 3'd1;
    localparam logic [2:0] KIND_STORE   = 3'd2;
    localparam logic [2:0] KIND_FWD     = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;
    localparam logic [2:0] KIND_BRERR   = 3'd5;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [2:0] MODE_LB  = 3'd0;
    localparam logic [2:0] MODE_LH  = 3'd1;
    localparam logic [2:0] MODE_LW  = 3'd2;
    localparam logic [2:0] MODE_LBU = 3'd3;
    localparam logic [2:0] MODE_LHU = 3'd4;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [4:0]  LINK_REG = 5'b11111;
    localparam logic [31:0] PC_SEG_MASK = 32'hF000_0000;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] instr;
        logic [31:0] pc;
        logic [31:0] ld;
    } item_t;

endpackage

// ===== hw/rtl/mips_i_immediate_op_execute.sv =====
// Throughput: one item per cycle while in_stall and out_stall stay low; the execute
// stage retires one item each cycle, unless out_stall holds its result register,
// through a single register file write port and two registered read ports.
// Reset: asynchronous, active low; clears queue, pipeline and pending state.
// Register file reads as zero after reset through per-entry valid bits.
module mips_i_immediate_op_execute #(
    parameter int QDEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] instr_word,
    input  logic [31:0] cur_pc,
    input  logic [31:0] load_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] mem_addr,
    output logic [1:0]  mem_size,
    output logic [31:0] store_data,
    output logic        branch_taken,
    output logic [31:0] branch_target
);

    logic                         push, pop, q_full, q_nonempty;
    mipse_pkg::item_t             push_item, head_item;
    logic [$clog2(QDEPTH+1)-1:0]  q_count;

    mipse_front u_front (
        .in_valid   (in_valid),
        .cmd        (cmd),
        .instr_word (instr_word),
        .cur_pc     (cur_pc),
        .load_data  (load_data),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_item  (push_item)
    );

    mipse_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head_item (head_item),
        .count     (q_count)
    );

    mipse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_nonempty    (q_nonempty),
        .q_item        (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .mem_addr      (mem_addr),
        .mem_size      (mem_size),
        .store_data    (store_data),
        .branch_taken  (branch_taken),
        .branch_target (branch_target)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(QDEPTH+1))'(QDEPTH))
        else $error("queue count overflow");

    a_taken_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken |-> kind == mipse_pkg::KIND_DONE)
        else $error("taken branch with non-done kind");

    a_mem_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != mipse_pkg::KIND_LOAD) && (kind != mipse_pkg::KIND_STORE)
        |-> mem_addr == '0 && store_data == '0)
        else $error("memory fields set on non-memory result");

    a_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_nonempty)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/mipse_front.sv =====
module mipse_front (
    input  logic                in_valid,
    input  logic                cmd,
    input  logic [31:0]         instr_word,
    input  logic [31:0]         cur_pc,
    input  logic [31:0]         load_data,
    input  logic                q_full,
    output logic                in_stall,
    output logic                push,
    output mipse_pkg::item_t    push_item
);

    logic [5:0]      op;
    mipse_pkg::cls_t cls;

    assign op = instr_word[31:26];

    always_comb
    begin
        case (op)
            mipse_pkg::OP_J:
                cls = mipse_pkg::CLS_JUMP;
            mipse_pkg::OP_JAL:
                cls = mipse_pkg::CLS_JAL;
            mipse_pkg::OP_BEQ, mipse_pkg::OP_BNE, mipse_pkg::OP_BLEZ, mipse_pkg::OP_BGTZ:
                cls = mipse_pkg::CLS_BRANCH;
            mipse_pkg::OP_ADDI, mipse_pkg::OP_ADDIU, mipse_pkg::OP_SLTI, mipse_pkg::OP_SLTIU,
            mipse_pkg::OP_ANDI, mipse_pkg::OP_ORI, mipse_pkg::OP_LUI:
                cls = mipse_pkg::CLS_ALU;
            mipse_pkg::OP_LB, mipse_pkg::OP_LH, mipse_pkg::OP_LW, mipse_pkg::OP_LBU,
            mipse_pkg::OP_LHU:
                cls = mipse_pkg::CLS_LOAD;
            mipse_pkg::OP_SB, mipse_pkg::OP_SH, mipse_pkg::OP_SW:
                cls = mipse_pkg::CLS_STORE;
            mipse_pkg::OP_SPECIAL, mipse_pkg::OP_REGIMM, mipse_pkg::OP_COP0:
                cls = mipse_pkg::CLS_FWD;
            default:
                cls = mipse_pkg::CLS_UNKNOWN;
        endcase
        if (cmd)
        begin
            cls = mipse_pkg::CLS_REPLY;
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.cls   = cls;
        push_item.instr = instr_word;
        push_item.pc    = cur_pc;
        push_item.ld    = load_data;
    end

endmodule

// ===== hw/rtl/mipse_queue.sv =====
module mipse_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mipse_pkg::item_t        push_item,
    input  logic                    pop,
    output logic                    full,
    output logic                    nonempty,
    output mipse_pkg::item_t        head_item,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mipse_pkg::item_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1))
        begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign nonempty  = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/mipse_back.sv =====
module mipse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  mipse_pkg::item_t    q_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          kind,
    output logic [31:0]         mem_addr,
    output logic [1:0]          mem_size,
    output logic [31:0]         store_data,
    output logic                branch_taken,
    output logic [31:0]         branch_target
);

    logic [31:0] gpr_mem [32];
    logic [31:0] gpr_vld_reg;

    mipse_pkg::item_t e_item_reg;
    logic        e_valid_reg, e_valid_next;
    logic [31:0] rd_a_reg, rd_b_reg;
    logic        vld_a_reg, vld_b_reg;
    logic        byp_a_reg, byp_b_reg;
    logic [31:0] byp_data_reg;

    logic [4:0]  pend_reg_reg, pend_reg_next;
    logic [2:0]  pend_mode_reg, pend_mode_next;
    logic        br_pend_reg, br_pend_next;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [31:0] mem_addr_reg;
    logic [1:0]  mem_size_reg;
    logic [31:0] store_data_reg;
    logic        taken_reg;
    logic [31:0] target_reg;

    logic        e_fire;
    logic        we;
    logic [4:0]  wa;
    logic [31:0] wd;
    logic [31:0] a, b;
    logic [5:0]  op;
    logic [4:0]  rt, q_rs, q_rt;
    logic [15:0] imm;
    logic [31:0] simm, zimm, sum;
    logic        cond, is_br;
    logic [2:0]  k;
    logic [31:0] addr_c, sdata_c, target_c;
    logic [1:0]  size_c;
    logic        taken_c;

    assign e_fire = e_valid_reg && (!out_valid_reg || !out_stall);
    assign pop    = q_nonempty && (!e_valid_reg || e_fire);
    assign q_rs   = q_item.instr[25:21];
    assign q_rt   = q_item.instr[20:16];

    // Bypass takes the write retiring on the same edge the operands are read
    assign a = byp_a_reg ? byp_data_reg : (vld_a_reg ? rd_a_reg : '0);
    assign b = byp_b_reg ? byp_data_reg : (vld_b_reg ? rd_b_reg : '0);

    assign op   = e_item_reg.instr[31:26];
    assign rt   = e_item_reg.instr[20:16];
    assign imm  = e_item_reg.instr[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'h0000, imm};
    assign sum  = a + simm;

    always_comb
    begin
        k              = mipse_pkg::KIND_DONE;
        addr_c         = '0;
        size_c         = mipse_pkg::SIZE_BYTE;
        sdata_c        = '0;
        taken_c        = 1'b0;
        target_c       = '0;
        we             = 1'b0;
        wa             = rt;
        wd             = '0;
        cond           = 1'b0;
        pend_reg_next  = pend_reg_reg;
        pend_mode_next = pend_mode_reg;
        br_pend_next   = br_pend_reg;
        is_br          = (e_item_reg.cls == mipse_pkg::CLS_JUMP)
                      || (e_item_reg.cls == mipse_pkg::CLS_JAL)
                      || (e_item_reg.cls == mipse_pkg::CLS_BRANCH);

        case (op)
            mipse_pkg::OP_BEQ:  cond = (a == b);
            mipse_pkg::OP_BNE:  cond = (a != b);
            mipse_pkg::OP_BLEZ: cond = a[31] || (a == '0);
            default:            cond = !a[31] && (a != '0);
        endcase

        if (e_item_reg.cls == mipse_pkg::CLS_REPLY)
        begin
            we = 1'b1;
            wa = pend_reg_reg;
            case (pend_mode_reg)
                mipse_pkg::MODE_LB:  wd = {{24{e_item_reg.ld[7]}}, e_item_reg.ld[7:0]};
                mipse_pkg::MODE_LH:  wd = {{16{e_item_reg.ld[15]}}, e_item_reg.ld[15:0]};
                mipse_pkg::MODE_LBU: wd = {24'h000000, e_item_reg.ld[7:0]};
                mipse_pkg::MODE_LHU: wd = {16'h0000, e_item_reg.ld[15:0]};
                default:             wd = e_item_reg.ld;
            endcase
            pend_reg_next = '0;
        end
        else
        begin
            br_pend_next = 1'b0;
            if (is_br && br_pend_reg)
            begin
                k = mipse_pkg::KIND_BRERR;
            end
            else
            begin
                case (e_item_reg.cls)
                    mipse_pkg::CLS_JUMP, mipse_pkg::CLS_JAL:
                    begin
                        taken_c  = 1'b1;
                        target_c = (e_item_reg.pc & mipse_pkg::PC_SEG_MASK)
                                 | {4'h0, e_item_reg.instr[25:0], 2'b00};
                        if (e_item_reg.cls == mipse_pkg::CLS_JAL)
                        begin
                            we = 1'b1;
                            wa = mipse_pkg::LINK_REG;
                            wd = e_item_reg.pc + 32'd4;
                        end
                    end
                    mipse_pkg::CLS_BRANCH:
                    begin
                        if (cond)
                        begin
                            taken_c  = 1'b1;
                            target_c = e_item_reg.pc + {simm[29:0], 2'b00};
                        end
                    end
                    mipse_pkg::CLS_ALU:
                    begin
                        we = 1'b1;
                        case (op)
                            mipse_pkg::OP_SLTI:  wd = {31'd0, $signed(a) < $signed(simm)};
                            mipse_pkg::OP_SLTIU: wd = {31'd0, a < simm};
                            mipse_pkg::OP_ANDI:  wd = a & zimm;
                            mipse_pkg::OP_ORI:   wd = a | zimm;
                            mipse_pkg::OP_LUI:   wd = {imm, 16'h0000};
                            default:             wd = sum;
                        endcase
                    end
                    mipse_pkg::CLS_LOAD:
                    begin
                        k             = mipse_pkg::KIND_LOAD;
                        addr_c        = sum;
                        pend_reg_next = rt;
                        case (op)
                            mipse_pkg::OP_LB:
                            begin
                                size_c = mipse_pkg::SIZE_BYTE;
                                pend_mode_next = mipse_pkg::MODE_LB;
                            end
                            mipse_pkg::OP_LH:
                            begin
                                size_c = mipse_pkg::SIZE_HALF;
                                pend_mode_next = mipse_pkg::MODE_LH;
                            end
                            mipse_pkg::OP_LBU:
                            begin
                                size_c = mipse_pkg::SIZE_BYTE;
                                pend_mode_next = mipse_pkg::MODE_LBU;
                            end
                            mipse_pkg::OP_LHU:
                            begin
                                size_c = mipse_pkg::SIZE_HALF;
                                pend_mode_next = mipse_pkg::MODE_LHU;
                            end
                            default:
                            begin
                                size_c = mipse_pkg::SIZE_WORD;
                                pend_mode_next = mipse_pkg::MODE_LW;
                            end
                        endcase
                    end
                    mipse_pkg::CLS_STORE:
                    begin
                        k      = mipse_pkg::KIND_STORE;
                        addr_c = sum;
                        case (op)
                            mipse_pkg::OP_SB:
                            begin
                                size_c  = mipse_pkg::SIZE_BYTE;
                                sdata_c = {24'h000000, b[7:0]};
                            end
                            mipse_pkg::OP_SH:
                            begin
                                size_c  = mipse_pkg::SIZE_HALF;
                                sdata_c = {16'h0000, b[15:0]};
                            end
                            default:
                            begin
                                size_c  = mipse_pkg::SIZE_WORD;
                                sdata_c = b;
                            end
                        endcase
                    end
                    mipse_pkg::CLS_FWD:
                        k = mipse_pkg::KIND_FWD;
                    default:
                        k = mipse_pkg::KIND_UNKNOWN;
                endcase
            end
            if (taken_c)
            begin
                br_pend_next = 1'b1;
            end
        end
        // drop writes to r0
        we = we && (wa != '0) && e_fire;
    end

    always_comb
    begin
        e_valid_next = e_valid_reg;
        if (pop)
        begin
            e_valid_next = 1'b1;
        end
        else if (e_fire)
        begin
            e_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            gpr_mem[wa] <= wd;
        end
        if (pop)
        begin
            rd_a_reg <= gpr_mem[q_rs];
            rd_b_reg <= gpr_mem[q_rt];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_item_reg   <= q_item;
            byp_data_reg <= wd;
        end
        if (e_fire)
        begin
            kind_reg       <= k;
            mem_addr_reg   <= addr_c;
            mem_size_reg   <= size_c;
            store_data_reg <= sdata_c;
            taken_reg      <= taken_c;
            target_reg     <= target_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_vld_reg   <= '0;
            e_valid_reg   <= 1'b0;
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            byp_a_reg     <= 1'b0;
            byp_b_reg     <= 1'b0;
            pend_reg_reg  <= '0;
            pend_mode_reg <= '0;
            br_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            if (we)
            begin
                gpr_vld_reg[wa] <= 1'b1;
            end
            if (pop)
            begin
                vld_a_reg <= gpr_vld_reg[q_rs];
                vld_b_reg <= gpr_vld_reg[q_rt];
                byp_a_reg <= we && (wa == q_rs);
                byp_b_reg <= we && (wa == q_rt);
            end
            if (e_fire)
            begin
                pend_reg_reg  <= pend_reg_next;
                pend_mode_reg <= pend_mode_next;
                br_pend_reg   <= br_pend_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign mem_addr      = mem_addr_reg;
    assign mem_size      = mem_size_reg;
    assign store_data    = store_data_reg;
    assign branch_taken  = taken_reg;
    assign branch_target = target_reg;

endmodule
